// ----- hw/rtl/fcsc_pkg.sv -----
// Shared types, constants and the symbol classifier for the FASTA composition counter.
`default_nettype none

package fcsc_pkg;

	localparam int FIRST_SEQ_DEPTH_DEF = 65536;

	localparam logic [7:0]  CHAR_GT   = 8'h3E; // '>'
	localparam logic [7:0]  CHAR_LF   = 8'h0A; // newline
	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
	localparam logic [15:0] ALL_ONES16 = 16'hFFFF;

	typedef enum logic [1:0] {
		CLS_GC,
		CLS_AT,
		CLS_AMB,
		CLS_ANO
	} sym_class_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [15:0] seq_index;
		logic [31:0] seq_length;
		logic [31:0] gc_count;
		logic [31:0] at_count;
		logic [31:0] ambiguous_count;
		logic [31:0] anomalous_count;
		logic [31:0] max_length;
		logic [31:0] min_length;
		logic [31:0] snp_count;
		logic        length_error;
		logic        final_record;
	} out_item_t;

	// Store-side control from the parser
	typedef struct packed {
		logic wr;    // write the byte of the first sequence
		logic cmp;   // compare the byte of the second sequence
		logic clear; // end of file: drop the mismatch count
	} store_req_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		sat_inc32 = (v == ALL_ONES32) ? v : v + 32'd1;
	endfunction

	function automatic sym_class_t classify(input logic [7:0] c);
		case (c) inside
			// C c G g
			8'h43, 8'h63, 8'h47, 8'h67: classify = CLS_GC;
			// A a T t
			8'h41, 8'h61, 8'h54, 8'h74: classify = CLS_AT;
			// R Y K M S W B D H V N in either case, and gap
			8'h52, 8'h59, 8'h4B, 8'h4D, 8'h53, 8'h57, 8'h42, 8'h44, 8'h48, 8'h56,
			8'h4E, 8'h72, 8'h79, 8'h6B, 8'h6D, 8'h73, 8'h77, 8'h62, 8'h64, 8'h68,
			8'h76, 8'h6E, 8'h2D: classify = CLS_AMB;
			default: classify = CLS_ANO;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fcsc_store.sv -----
// First-sequence store and the compare stage that counts SNPs of the second sequence.
`default_nettype none

module fcsc_store #(
	parameter int FIRST_SEQ_DEPTH = fcsc_pkg::FIRST_SEQ_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fcsc_pkg::store_req_t               req,
	input  wire logic [$clog2(FIRST_SEQ_DEPTH)-1:0] addr,
	input  wire logic [7:0]                         wr_data,
	output logic [31:0]                             mismatch_total
);
	import fcsc_pkg::*;

	logic [7:0]  mem [FIRST_SEQ_DEPTH];
	logic [7:0]  rd_data_s1;
	logic [7:0]  byte_s1;
	logic        cmp_s1;
	logic [31:0] mismatch_q;
	logic        pending_hit;

	// Write the first sequence, read for the second
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wr_data;
		end
		rd_data_s1 <= mem[addr];
		byte_s1    <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
		end else begin
			cmp_s1 <= req.cmp && !req.clear;
		end
	end

	// Fold in the compare still in flight so a close in this cycle sees it
	assign pending_hit    = cmp_s1 && (rd_data_s1 != byte_s1);
	assign mismatch_total = pending_hit ? sat_inc32(mismatch_q) : mismatch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= '0;
		end else if (req.clear) begin
			mismatch_q <= '0;
		end else begin
			mismatch_q <= mismatch_total;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fcsc_core.sv -----
// Line parser, per-sequence counters and record builder.
`default_nettype none

module fcsc_core #(
	parameter int FIRST_SEQ_DEPTH = fcsc_pkg::FIRST_SEQ_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               accept,
	input  wire fcsc_pkg::in_item_t                 in_data,
	input  wire logic [31:0]                        mismatch_total,
	output fcsc_pkg::store_req_t                    req,
	output logic [$clog2(FIRST_SEQ_DEPTH)-1:0]      addr,
	output logic [7:0]                              wr_data,
	output logic                                    rec_push,
	output fcsc_pkg::out_item_t                     rec
);
	import fcsc_pkg::*;

	localparam int         AW     = $clog2(FIRST_SEQ_DEPTH);
	localparam logic [32:0] DepthW = 33'(FIRST_SEQ_DEPTH);

	logic        at_line_start_q;
	logic        in_header_q;
	logic        have_seq_q;
	logic [15:0] seq_cnt_q;
	logic [31:0] len_q, gc_q, at_q, amb_q, ano_q;
	logic [31:0] max_q, min_q, first_len_q;

	logic        c_eoi, c_lf, c_hdr, c_sym;
	logic [7:0]  c;
	logic        pos_in_depth;
	logic        is_seq0, is_seq1;
	logic [31:0] new_max, new_min;
	sym_class_t  cls;

	// Decode the accepted byte
	assign c       = in_data.byte_in;
	assign c_eoi   = accept && in_data.end_of_input;
	assign c_lf    = accept && !in_data.end_of_input && (c == CHAR_LF);
	assign c_hdr   = accept && !in_data.end_of_input && (c == CHAR_GT) && at_line_start_q;
	assign c_sym   = accept && !in_data.end_of_input && !c_lf && !c_hdr
		&& !in_header_q && have_seq_q;
	assign cls     = classify(c);

	assign is_seq0      = (seq_cnt_q == 16'd0);
	assign is_seq1      = (seq_cnt_q == 16'd1);
	assign pos_in_depth = ({1'b0, len_q} < DepthW);

	// Drive the store
	assign addr      = len_q[AW-1:0];
	assign wr_data   = c;
	assign req.wr    = c_sym && is_seq0 && pos_in_depth;
	assign req.cmp   = c_sym && is_seq1 && pos_in_depth && (len_q < first_len_q);
	assign req.clear = c_eoi;

	// Build the record of the open sequence
	assign new_max = (len_q > max_q) ? len_q : max_q;
	assign new_min = (len_q < min_q) ? len_q : min_q;

	assign rec_push = (c_eoi || c_hdr) && have_seq_q;

	always_comb begin
		rec.seq_index       = seq_cnt_q;
		rec.seq_length      = len_q;
		rec.gc_count        = gc_q;
		rec.at_count        = at_q;
		rec.ambiguous_count = amb_q;
		rec.anomalous_count = ano_q;
		rec.max_length      = new_max;
		rec.min_length      = new_min;
		rec.snp_count       = is_seq1 ? mismatch_total : '0;
		rec.length_error    = is_seq1 && ((len_q != first_len_q) || ({1'b0, len_q} > DepthW));
		rec.final_record    = c_eoi;
	end

	// Advance parser and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			in_header_q     <= 1'b0;
			have_seq_q      <= 1'b0;
			seq_cnt_q       <= '0;
			len_q           <= '0;
			gc_q            <= '0;
			at_q            <= '0;
			amb_q           <= '0;
			ano_q           <= '0;
			max_q           <= '0;
			min_q           <= ALL_ONES32;
			first_len_q     <= '0;
		end else if (c_eoi) begin
			// end of file: back to the reset state
			at_line_start_q <= 1'b1;
			in_header_q     <= 1'b0;
			have_seq_q      <= 1'b0;
			seq_cnt_q       <= '0;
			len_q           <= '0;
			gc_q            <= '0;
			at_q            <= '0;
			amb_q           <= '0;
			ano_q           <= '0;
			max_q           <= '0;
			min_q           <= ALL_ONES32;
			first_len_q     <= '0;
		end else if (c_lf) begin
			in_header_q     <= 1'b0;
			at_line_start_q <= 1'b1;
		end else if (c_hdr) begin
			at_line_start_q <= 1'b0;
			in_header_q     <= 1'b1;
			have_seq_q      <= 1'b1;
			len_q           <= '0;
			gc_q            <= '0;
			at_q            <= '0;
			amb_q           <= '0;
			ano_q           <= '0;
			if (have_seq_q) begin
				max_q <= new_max;
				min_q <= new_min;
				if (is_seq0) begin
					first_len_q <= len_q;
				end
				if (seq_cnt_q != ALL_ONES16) begin
					seq_cnt_q <= seq_cnt_q + 16'd1;
				end
			end
		end else if (accept) begin
			at_line_start_q <= 1'b0;
			if (c_sym) begin
				len_q <= sat_inc32(len_q);
				case (cls)
					CLS_GC:  gc_q  <= sat_inc32(gc_q);
					CLS_AT:  at_q  <= sat_inc32(at_q);
					CLS_AMB: amb_q <= sat_inc32(amb_q);
					default: ano_q <= sat_inc32(ano_q);
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fcsc_out_buf.sv -----
// Two-entry output buffer that keeps records flowing while the receiver stalls.
`default_nettype none

module fcsc_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fcsc_pkg::out_item_t rec,
	output logic                     space,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fcsc_pkg::out_item_t      out_data
);
	import fcsc_pkg::*;

	out_item_t head_q, skid_q;
	logic      head_valid_q, skid_valid_q;
	logic      pop;

	assign pop       = head_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;

	// Hold control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	// Move payloads
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= rec;
				end
			end else if (push) begin
				head_q <= rec;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_q <= rec;
			end else begin
				head_q <= rec;
			end
		end
	end

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry held without a head entry");

	a_push_stalled_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && head_valid_q |=> skid_valid_q)
		else $error("record dropped while receiver stalled");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !skid_valid_q && !push |=> !head_valid_q)
		else $error("record repeated after transfer");

endmodule

`default_nettype wire

// ----- hw/rtl/fasta_composition_and_snp_counter.sv -----
// Top level of the FASTA composition and SNP counter.
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one file byte per transfer,
//   or an end-of-file marker (end_of_input set, byte ignored).
//   Output channel (out_valid/out_ready/out_data) carries one record per closed
//   sequence: at the next header line or at end of file.
// Throughput: one byte per cycle while the output buffer has space (in_ready high).
// Records: a record is registered into the output buffer when the closing header byte
//   or end-of-file marker is transferred, and is shown on out_valid from there.
// The first sequence is written into an on-chip store of FIRST_SEQ_DEPTH bytes;
//   the second is read back one byte per cycle while in_ready is high, the read
//   data registered and the compare folded into the SNP count in the cycle after,
//   so the store port sets the one-byte-per-cycle rate.
// Stall: a two-entry output buffer absorbs a waiting record; in_ready falls only
//   while two records wait.
// Reset: arst_n clears the parser, counters and output buffer at once; the store
//   needs no clearing. End of file also resets the parser, counters and SNP count.
`default_nettype none

module fasta_composition_and_snp_counter #(
	parameter int FIRST_SEQ_DEPTH = fcsc_pkg::FIRST_SEQ_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fcsc_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fcsc_pkg::out_item_t      out_data
);
	import fcsc_pkg::*;

	localparam int AW = $clog2(FIRST_SEQ_DEPTH);

	logic        accept;
	logic        space;
	logic        rec_push;
	out_item_t   rec;
	store_req_t  req;
	logic [AW-1:0] addr;
	logic [7:0]  wr_data;
	logic [31:0] mismatch_total;

	assign in_ready = space;
	assign accept   = in_valid && space;

	fcsc_core #(
		.FIRST_SEQ_DEPTH(FIRST_SEQ_DEPTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_data        (in_data),
		.mismatch_total (mismatch_total),
		.req            (req),
		.addr           (addr),
		.wr_data        (wr_data),
		.rec_push       (rec_push),
		.rec            (rec)
	);

	fcsc_store #(
		.FIRST_SEQ_DEPTH(FIRST_SEQ_DEPTH)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.addr           (addr),
		.wr_data        (wr_data),
		.mismatch_total (mismatch_total)
	);

	fcsc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.rec       (rec),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
